### rtl/i2cms_pkg.sv
package i2cms_pkg;

	// bus count and derived widths
	localparam int BUS_COUNT = 3;
	localparam int BUS_W     = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;
	localparam int PIN_W     = 3;  // fixed width of pin fields on the ports
	localparam int TICK_W    = 8;
	localparam int BYTE_W    = 8;
	localparam int BIT_W     = 4;
	localparam int IDX_W     = 3;  // width of the bus_index field

	localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

	// config register indexes
	localparam logic CFG_PHASE_TICKS = 1'b0;
	localparam logic CFG_BUS_ENABLE  = 1'b1;

	localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 8'd4;
	localparam logic [PIN_W-1:0]  BUS_ENABLE_RST  = 3'd7;

	// queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_ST_A,
		PH_ST_B,
		PH_ST_C,
		PH_WR_SET,
		PH_WR_HI,
		PH_WACK_A,
		PH_WACK_B,
		PH_WACK_C,
		PH_RD_HI,
		PH_RD_LO,
		PH_RACK_A,
		PH_RACK_B,
		PH_RACK_C,
		PH_SP_A,
		PH_SP_B
	} phase_t;

	typedef struct packed {
		logic [TICK_W-1:0] phase_ticks;
		logic [PIN_W-1:0]  bus_enable;
	} cfg_t;

	// one classified tick as it travels from front to back
	typedef struct packed {
		logic              cmd_ok;   // command for an enabled, existing bus
		logic              is_read;
		logic [BUS_W-1:0]  bus;
		logic              start;
		logic              stop;
		logic [BYTE_W-1:0] tx_byte;
		logic              ack;
		logic [PIN_W-1:0]  sda_in;
	} tick_t;

endpackage

### rtl/i2c_master_byte_sequencer.sv
// Bit-level open-drain I2C master for BUS_COUNT buses. Every input beat is one
// sequencer tick and produces exactly one output beat carrying the SCL/SDA pin
// levels of all buses, busy, and a received byte. A tick with cmd_valid set
// while the sequencer is idle starts a byte command on bus_index: optional
// START, eight bits written MSB first plus an unsampled ACK clock, or eight
// bits read plus a master ACK/NACK, then optional STOP. Each pin step holds
// for phase_ticks ticks (0 acts as 1). Commands arriving while busy, or for a
// bus that is out of range or disabled in bus_enable, are dropped.
// Rate: one beat per cycle in and out. A front stage classifies each beat
// and writes it to a 4-entry queue; the back sequencer retires one queued beat
// per cycle into the output register, so input stalls only when the queue
// fills under output backpressure. Beats pass the queue, then the output
// register. Config writes take effect at once and are meant for idle times.
module i2c_master_byte_sequencer import i2cms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// tick beats in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] bus_index, [3] start_before, [4] stop_after, [12:5] tx_byte,
	// [13] ack_to_send, [16:14] sda_in_lines, rest zero
	input  logic [23:0] s_axis_tdata,
	// [0] cmd_valid, [1] mode
	input  logic [1:0]  s_axis_tuser,
	// result beats out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] scl_lines, [5:3] sda_lines, [6] busy_res, [14:7] rx_byte, [15] zero
	output logic [15:0] m_axis_tdata,
	// [0] rx_valid
	output logic [0:0]  m_axis_tuser
);

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_not_empty;
	tick_t push_item;
	tick_t pop_item;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_ticks <= PHASE_TICKS_RST;
			cfg_q.bus_enable  <= BUS_ENABLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PHASE_TICKS: cfg_q.phase_ticks <= cfg_data;
				CFG_BUS_ENABLE:  cfg_q.bus_enable  <= cfg_data[PIN_W-1:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	i2cms_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg           (cfg_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	i2cms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	i2cms_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_not_empty   (q_not_empty),
		.q_item        (pop_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

### rtl/i2cms_front.sv
module i2cms_front import i2cms_pkg::*; (
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  cfg_t        cfg,
	input  logic        q_full,
	output logic        q_push,
	output tick_t       q_item
);

	logic             cmd_valid;
	logic [IDX_W-1:0] idx;
	logic             bus_on;
	logic             in_range;

	assign cmd_valid = s_axis_tuser[0];
	assign idx       = s_axis_tdata[2:0];
	assign in_range  = 32'(idx) < BUS_COUNT;
	assign bus_on    = |((cfg.bus_enable >> idx) & PIN_W'(1));

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	always_comb begin
		q_item.cmd_ok  = cmd_valid && in_range && bus_on;
		q_item.is_read = s_axis_tuser[1];
		q_item.bus     = idx[BUS_W-1:0];
		q_item.start   = s_axis_tdata[3];
		q_item.stop    = s_axis_tdata[4];
		q_item.tx_byte = s_axis_tdata[12:5];
		q_item.ack     = s_axis_tdata[13];
		q_item.sda_in  = s_axis_tdata[16:14];
	end

endmodule

### rtl/i2cms_queue.sv
module i2cms_queue import i2cms_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  tick_t push_item,
	input  logic  pop,
	output tick_t pop_item,
	output logic  full,
	output logic  not_empty
);

	tick_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = count_q == (QPTR_W+1)'(QDEPTH);
	assign not_empty = count_q != '0;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/i2cms_back.sv
module i2cms_back import i2cms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_not_empty,
	input  tick_t       q_item,
	output logic        q_pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,
	output logic [0:0]  m_axis_tuser
);

	phase_t             step_q, step_d;
	logic [TICK_W-1:0]  pc_q, pc_d;
	logic [BIT_W-1:0]   bit_q, bit_d;
	logic [BYTE_W-1:0]  shift_q, shift_d;
	logic [BUS_W-1:0]   bus_q, bus_d;
	logic               rd_q, rd_d;
	logic               stop_q, stop_d;
	logic               ack_q, ack_d;
	logic [BUS_COUNT-1:0] scl_q, scl_d;
	logic [BUS_COUNT-1:0] sda_q, sda_d;

	// output register
	logic               ov_q;
	logic [PIN_W-1:0]   o_scl_q, o_sda_q;
	logic               o_busy_q;
	logic [BYTE_W-1:0]  o_rx_q;
	logic               o_rxv_q;

	logic [TICK_W-1:0]  pc_load;
	phase_t             tgt;
	logic               ent;
	logic               done;

	assign q_pop   = q_not_empty && (!ov_q || m_axis_tready);
	assign pc_load = (cfg.phase_ticks == '0) ? '0 : cfg.phase_ticks - 1'b1;

	always_comb begin
		step_d  = step_q;
		pc_d    = pc_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		bus_d   = bus_q;
		rd_d    = rd_q;
		stop_d  = stop_q;
		ack_d   = ack_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		tgt     = PH_IDLE;
		ent     = 1'b0;
		done    = 1'b0;

		if (step_q == PH_IDLE) begin
			if (q_item.cmd_ok) begin
				bus_d   = q_item.bus;
				rd_d    = q_item.is_read;
				stop_d  = q_item.stop;
				ack_d   = q_item.ack;
				bit_d   = '0;
				shift_d = q_item.is_read ? '0 : q_item.tx_byte;
				ent     = 1'b1;
				if (q_item.start) begin
					tgt = PH_ST_A;
				end else begin
					tgt = q_item.is_read ? PH_RD_HI : PH_WR_SET;
				end
			end
		end else if (pc_q != '0) begin
			pc_d = pc_q - 1'b1;
		end else begin
			ent = 1'b1;
			case (step_q)
				PH_ST_A:   tgt = PH_ST_B;
				PH_ST_B:   tgt = PH_ST_C;
				PH_ST_C:   tgt = rd_q ? PH_RD_HI : PH_WR_SET;
				PH_WR_SET: tgt = PH_WR_HI;
				PH_WR_HI: begin
					shift_d = {shift_q[BYTE_W-2:0], 1'b0};
					bit_d   = bit_q + 1'b1;
					tgt     = (bit_d >= BITS_PER_BYTE) ? PH_WACK_A : PH_WR_SET;
				end
				PH_WACK_A: tgt = PH_WACK_B;
				PH_WACK_B: tgt = PH_WACK_C;
				PH_WACK_C: tgt = stop_q ? PH_SP_A : PH_IDLE;
				PH_RD_HI: begin
					shift_d = {shift_q[BYTE_W-2:0], q_item.sda_in[bus_q]};
					bit_d   = bit_q + 1'b1;
					done    = bit_d == BITS_PER_BYTE;
					tgt     = PH_RD_LO;
				end
				PH_RD_LO:  tgt = (bit_q >= BITS_PER_BYTE) ? PH_RACK_A : PH_RD_HI;
				PH_RACK_A: tgt = PH_RACK_B;
				PH_RACK_B: tgt = PH_RACK_C;
				PH_RACK_C: tgt = stop_q ? PH_SP_A : PH_IDLE;
				PH_SP_A:   tgt = PH_SP_B;
				default:   tgt = PH_IDLE;
			endcase
		end

		// entering a phase: load its length and set its pins on the served bus
		if (ent) begin
			step_d = tgt;
			pc_d   = pc_load;
			case (tgt)
				PH_ST_A: begin
					sda_d[bus_d] = 1'b1;
					scl_d[bus_d] = 1'b1;
				end
				PH_ST_B:   sda_d[bus_d] = 1'b0;
				PH_ST_C:   scl_d[bus_d] = 1'b0;
				PH_WR_SET: begin
					scl_d[bus_d] = 1'b0;
					sda_d[bus_d] = shift_d[BYTE_W-1];
				end
				PH_WR_HI:  scl_d[bus_d] = 1'b1;
				PH_WACK_A: begin
					scl_d[bus_d] = 1'b0;
					sda_d[bus_d] = 1'b1;
				end
				PH_WACK_B: scl_d[bus_d] = 1'b1;
				PH_WACK_C: scl_d[bus_d] = 1'b0;
				PH_RD_HI: begin
					sda_d[bus_d] = 1'b1;
					scl_d[bus_d] = 1'b1;
				end
				PH_RD_LO:  scl_d[bus_d] = 1'b0;
				PH_RACK_A: sda_d[bus_d] = !ack_d;
				PH_RACK_B: scl_d[bus_d] = 1'b1;
				PH_RACK_C: scl_d[bus_d] = 1'b0;
				PH_SP_A: begin
					sda_d[bus_d] = 1'b0;
					scl_d[bus_d] = 1'b1;
				end
				PH_SP_B:   sda_d[bus_d] = 1'b1;
				default: begin
					step_d = PH_IDLE;
					pc_d   = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= PH_IDLE;
			pc_q    <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			bus_q   <= '0;
			rd_q    <= 1'b0;
			stop_q  <= 1'b0;
			ack_q   <= 1'b0;
			scl_q   <= '1;
			sda_q   <= '1;
			ov_q    <= 1'b0;
		end else begin
			if (q_pop) begin
				step_q  <= step_d;
				pc_q    <= pc_d;
				bit_q   <= bit_d;
				shift_q <= shift_d;
				bus_q   <= bus_d;
				rd_q    <= rd_d;
				stop_q  <= stop_d;
				ack_q   <= ack_d;
				scl_q   <= scl_d;
				sda_q   <= sda_d;
				ov_q    <= 1'b1;
			end else if (m_axis_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			o_scl_q  <= PIN_W'(scl_d);
			o_sda_q  <= PIN_W'(sda_d);
			o_busy_q <= step_d != PH_IDLE;
			o_rx_q   <= done ? shift_d : '0;
			o_rxv_q  <= done;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {1'b0, o_rx_q, o_busy_q, o_sda_q, o_scl_q};
	assign m_axis_tuser  = o_rxv_q;

endmodule

### rtl/i2cms_checker.sv
module i2cms_checker import i2cms_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	logic [PIN_W-1:0] last_scl_q;
	logic [PIN_W-1:0] last_sda_q;
	logic             out_beat;

	assign out_beat = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_scl_q <= '1;
			last_sda_q <= '1;
		end else if (out_beat) begin
			last_scl_q <= m_axis_tdata[2:0];
			last_sda_q <= m_axis_tdata[5:3];
		end
	end

	// a completed read always leaves the sequencer busy for the ACK phases
	a_rx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[6])
		else $error("rx_valid without busy");

	// rx_byte is zero outside the completing tick
	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[14:7] == '0)
		else $error("rx_byte nonzero without rx_valid");

	// one tick moves pins of at most one bus
	a_one_bus: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> $countones((m_axis_tdata[2:0] ^ last_scl_q) |
		                        (m_axis_tdata[5:3] ^ last_sda_q)) <= 1)
		else $error("pins of more than one bus changed in one tick");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

endmodule

bind i2c_master_byte_sequencer i2cms_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
